[hdl/fpcm_pkg.sv]
package fpcm_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE   = 3'd1;
  localparam logic [2:0] ST_MISALIGNED = 3'd2;
  localparam logic [2:0] ST_BAD_TARGET = 3'd3;
  localparam logic [2:0] ST_REPEAT     = 3'd4;
  localparam logic [2:0] ST_NO_FREE    = 3'd5;
  localparam logic [2:0] ST_NO_DELETE  = 3'd6;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] TYPE_INSTR   = 2'd0;
  localparam logic [1:0] TYPE_LITERAL = 2'd1;

  localparam int LIT_SLOT_A = 6;
  localparam int LIT_SLOT_B = 7;

  localparam logic [31:0] WINDOW_START_RST = 32'h0220_0000;
  localparam logic [31:0] WINDOW_END_RST   = 32'h0221_4000;

  // Thumb-2 B.W encoding of a 25-bit offset, halfword-swapped for the remap word.
  function automatic logic [31:0] encode_bw(input logic [24:0] off);
    logic        s;
    logic        j1;
    logic        j2;
    logic [15:0] hi;
    logic [15:0] lo;
    s  = off[24];
    j1 = ~(off[23] ^ s);
    j2 = ~(off[22] ^ s);
    hi = {5'b11110, s, off[21:12]};
    lo = {2'b10, j1, 1'b1, j2, off[11:1]};
    return {lo, hi};
  endfunction

  // The distance must be nonzero and within plus or minus 16 MiB inclusive.
  function automatic logic dist_in_reach(input logic [31:0] d);
    logic pos_ok;
    logic neg_ok;
    pos_ok = !d[31] && (d[31:25] == 7'd0) && (!d[24] || (d[23:0] == 24'd0));
    neg_ok = (d[31:24] == 8'hFF);
    return (d != 32'd0) && (pos_ok || neg_ok);
  endfunction

endpackage

[hdl/flash_patch_comparator_manager_unit.sv]
// Flash-patch comparator manager. Each input word adds or deletes one instruction or literal
// patch and returns exactly one result word with a status, the slot concerned and the remap
// word written. The comparator addresses sit in a memory with one read and one write port,
// read one entry per cycle under a small sequencer, with the compare overlapped with the next
// read. The scan covers the COMPARATORS - 2 instruction slots or the two literal slots and
// stops early on a match. An instruction add that finds a free slot passes through the
// branch encoding state before its result, while every other scanned request goes from the
// scan straight to the result state. A word rejected on type, alignment or window goes
// from the check straight to the result state. A result that finds the output register
// still occupied waits there until out_ready frees it. One word is worked on at a time,
// and in_ready rises again in the cycle after the result is loaded, so the next
// word can be accepted while the previous result still waits in the output register. Per-entry
// enable bits clear at reset, so the block is usable right after reset without a clearing pass.
module flash_patch_comparator_manager_unit
  import fpcm_pkg::*;
#(
  parameter int COMPARATORS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [1:0]  in_patch_type,
  input  logic [31:0] in_old_addr,
  input  logic [31:0] in_patch_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_slot,
  output logic [31:0] out_remap_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(COMPARATORS);
  localparam logic [IW-1:0] SLOT_A    = IW'(LIT_SLOT_A);
  localparam logic [IW-1:0] SLOT_B    = IW'(LIT_SLOT_B);
  localparam logic [IW-1:0] SLOT_SKIP = IW'(LIT_SLOT_B + 1);
  localparam logic [IW-1:0] LAST_INSTR =
    (COMPARATORS > LIT_SLOT_B + 1) ? IW'(COMPARATORS - 1) : IW'(LIT_SLOT_A - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ENC   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic        cmd_r;
  logic [1:0]  type_r;
  logic [31:0] addr_r;
  logic [31:0] value_r;
  logic [31:0] dist_r, dist_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic        iss_r, iss_nxt;
  logic        pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic        pend_last_r, pend_last_nxt;
  logic        have_free_r, have_free_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic [2:0]  res_slot_r, res_slot_nxt;
  logic [31:0] res_word_r, res_word_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r;
  logic [2:0]  out_slot_r;
  logic [31:0] out_remap_word_r;
  logic [31:0] win_start_r;
  logic [31:0] win_end_r;
  logic [COMPARATORS-1:0] vld_r, vld_nxt;

  logic [31:0] cmp_mem [COMPARATORS];
  logic [31:0] remap_mem [COMPARATORS];
  logic [31:0] rd_key_r;
  logic        rd_vld_r;

  logic        mem_we;
  logic [IW-1:0] mem_wa;
  logic [31:0] remap_wd;

  logic        accept;
  logic        out_load;
  logic        lit;
  logic [31:0] key;
  logic        hit;
  logic        free_now;
  logic [IW-1:0] free_slot_now;
  logic [24:0] off;
  logic        cfg_wr;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign lit      = (type_r == TYPE_LITERAL);
  assign key      = {addr_r[31:1], 1'b1};
  assign hit      = rd_vld_r && (rd_key_r == key);
  assign free_now = have_free_r || !rd_vld_r;
  assign free_slot_now = have_free_r ? free_r : pend_idx_r;
  assign off      = dist_r[24:0] - 25'd4;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    dist_nxt       = dist_r;
    idx_nxt        = idx_r;
    iss_nxt        = iss_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    pend_last_nxt  = pend_last_r;
    have_free_nxt  = have_free_r;
    free_nxt       = free_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_word_nxt   = res_word_r;
    vld_nxt        = vld_r;
    mem_we         = 1'b0;
    mem_wa         = free_r;
    remap_wd       = value_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_status_nxt = ST_OK;
        res_slot_nxt   = 3'd0;
        res_word_nxt   = 32'd0;
        dist_nxt       = value_r - addr_r;
        idx_nxt        = lit ? SLOT_A : '0;
        iss_nxt        = 1'b1;
        have_free_nxt  = 1'b0;
        state_nxt      = S_SCAN;
        if (type_r[1]) begin
          res_status_nxt = ST_BAD_TYPE;
          state_nxt      = S_RESP;
        end else if (cmd_r == CMD_ADD && lit && (addr_r[1:0] != 2'd0)) begin
          res_status_nxt = ST_MISALIGNED;
          state_nxt      = S_RESP;
        end else if (cmd_r == CMD_ADD && lit &&
                     (addr_r < win_start_r || addr_r >= win_end_r)) begin
          res_status_nxt = ST_BAD_TARGET;
          state_nxt      = S_RESP;
        end else if (cmd_r == CMD_ADD && !lit && addr_r[1]) begin
          res_status_nxt = ST_MISALIGNED;
          state_nxt      = S_RESP;
        end
      end
      S_SCAN: begin
        if (iss_r) begin
          pend_nxt      = 1'b1;
          pend_idx_nxt  = idx_r;
          pend_last_nxt = lit ? (idx_r == SLOT_B) : (idx_r == LAST_INSTR);
          if (lit ? (idx_r == SLOT_B) : (idx_r == LAST_INSTR)) begin
            iss_nxt = 1'b0;
          end else if (!lit && idx_r == SLOT_A - 1'b1) begin
            idx_nxt = SLOT_SKIP;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
        if (pend_r) begin
          if (!have_free_r && !rd_vld_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = pend_idx_r;
          end
          if (hit) begin
            pend_nxt     = 1'b0;
            res_slot_nxt = pend_idx_r[2:0];
            state_nxt    = S_RESP;
            if (cmd_r == CMD_DELETE) begin
              vld_nxt[pend_idx_r] = 1'b0;
            end else begin
              res_status_nxt = ST_REPEAT;
            end
          end else if (pend_last_r) begin
            pend_nxt  = 1'b0;
            state_nxt = S_RESP;
            free_nxt  = free_slot_now;
            if (cmd_r == CMD_DELETE) begin
              res_status_nxt = ST_NO_DELETE;
            end else if (!free_now) begin
              res_status_nxt = ST_NO_FREE;
            end else if (lit) begin
              mem_we                 = 1'b1;
              mem_wa                 = free_slot_now;
              vld_nxt[free_slot_now] = 1'b1;
              res_slot_nxt           = free_slot_now[2:0];
              res_word_nxt           = value_r;
            end else begin
              state_nxt = S_ENC;
            end
          end
        end
      end
      S_ENC: begin
        state_nxt = S_RESP;
        remap_wd  = encode_bw(off);
        if (dist_in_reach(dist_r)) begin
          mem_we          = 1'b1;
          vld_nxt[free_r] = 1'b1;
          res_slot_nxt    = free_r[2:0];
          res_word_nxt    = encode_bw(off);
        end else begin
          res_status_nxt = ST_BAD_TARGET;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= 1'b0;
      pend_r      <= 1'b0;
      have_free_r <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      win_start_r <= WINDOW_START_RST;
      win_end_r   <= WINDOW_END_RST;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      have_free_r <= have_free_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
      if (cfg_wr && !paddr[2]) begin
        win_start_r <= pwdata;
      end
      if (cfg_wr && paddr[2]) begin
        win_end_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      type_r  <= in_patch_type;
      addr_r  <= in_old_addr;
      value_r <= in_patch_value;
    end
    dist_r       <= dist_nxt;
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_last_r  <= pend_last_nxt;
    free_r       <= free_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_word_r   <= res_word_nxt;
    if (out_load) begin
      out_status_r     <= res_status_r;
      out_slot_r       <= res_slot_r;
      out_remap_word_r <= res_word_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r <= cmp_mem[idx_r];
    rd_vld_r <= vld_r[idx_r];
    if (mem_we) begin
      cmp_mem[mem_wa]   <= key;
      remap_mem[mem_wa] <= remap_wd;
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? win_end_r : win_start_r;

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_remap_word = out_remap_word_r;

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN))
    else $error("compare pending outside the slot scan");

  a_lit_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && lit && iss_r) |-> (idx_r == SLOT_A || idx_r == SLOT_B))
    else $error("literal scan left slots six and seven");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !(out_status == ST_OK || out_status == ST_REPEAT)) |-> (out_slot == 3'd0))
    else $error("slot reported on a failed request");

  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_remap_word == 32'd0))
    else $error("remap word reported on a failed request");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 3'd7))
    else $error("status code out of range");

endmodule
